### src/skd_pkg.sv
`default_nettype none
package skd_pkg;

	localparam int TABLE_ENTRIES = 512;
	localparam int MAX_KEY_CHARS = 8;

	localparam int ID_W   = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int SL_W   = CNT_W + 1;
	localparam int PK_W   = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
	localparam int POS_W  = $clog2(MAX_KEY_CHARS + 1);
	localparam int KEY_AW = ID_W + PK_W;
	localparam int CH_W   = 16;

	localparam logic [CH_W-1:0] CH_UPPER_A = 16'h0041;
	localparam logic [CH_W-1:0] CH_UPPER_Z = 16'h005A;
	localparam logic [CH_W-1:0] CH_FOLD    = 16'd32;

	localparam logic [2:0] STS_FOUND    = 3'd0;
	localparam logic [2:0] STS_INSERTED = 3'd1;
	localparam logic [2:0] STS_MISSING  = 3'd2;
	localparam logic [2:0] STS_FULL     = 3'd3;
	localparam logic [2:0] STS_TOO_LONG = 3'd4;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef struct packed {
		logic            cmd;
		logic [CH_W-1:0] char_code;
		logic            last_char;
	} key_beat_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] entry_id;
		logic [ID_W-1:0] sorted_position;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0] rd_addr;
		logic            we;
		logic [ID_W-1:0] wr_addr;
		logic [ID_W-1:0] wr_data;
	} idx_req_t;

	typedef struct packed {
		logic [ID_W-1:0]  rd_id;
		logic [PK_W-1:0]  rd_pos;
		logic             we_char;
		logic             we_len;
		logic [ID_W-1:0]  wr_id;
		logic [PK_W-1:0]  wr_pos;
		logic [CH_W-1:0]  wr_char;
		logic [POS_W-1:0] wr_len;
	} key_req_t;

	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [POS_W-1:0] len;
	} key_rd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] range_low;
		logic [CNT_W-1:0] range_high;
		logic             miss;
	} skd_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHK, ST_FA, ST_FB, ST_FC, ST_FINAL,
		ST_SRD, ST_SWR, ST_PLACE, ST_KEYWR, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MD_MID, MD_DOWN, MD_UP, MD_END
	} mode_t;

endpackage
`default_nettype wire

### src/sorted_key_dictionary.sv
// Sorted key dictionary.
// Keys arrive one character per beat on the key channel (key_valid, key_ready,
// key_char); last_char marks the final beat, and cmd on that beat selects
// insert or lookup. A-Z is folded to lower case.
// One result beat per key leaves on res_valid, res_ready, res_data.
// Each stored character probe reads the index memory, then the key memory,
// then compares. An accepted character that follows no miss is narrowed by
// binary search probes (up to ten), then by probes of the neighbor entries
// on both sides until one differs. On the final beat a nonempty range gets
// one more probe for a match check. An insert shifts each index entry at or
// above the insert point up by one, places the new id, then writes each key
// character and the length. Every result enters the output register; while it
// is not taken the next key's characters are still accepted, and only the next
// result waits. Reset empties the table; the memories need no clearing pass
// since only entries below the entry count are ever used.
`default_nettype none
module sorted_key_dictionary (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 key_valid,
	output logic                key_ready,
	input  skd_pkg::key_beat_t  key_char,
	output logic                res_valid,
	input  wire                 res_ready,
	output skd_pkg::result_t    res_data
);
	import skd_pkg::*;

	idx_req_t        idx_req;
	logic [ID_W-1:0] idx_rdata;
	key_req_t        key_req;
	key_rd_t         key_rd;
	skd_stat_t       stat;

	skd_index_mem u_index (
		.clk   (clk),
		.req   (idx_req),
		.rdata (idx_rdata)
	);

	skd_key_mem u_keys (
		.clk (clk),
		.req (key_req),
		.rd  (key_rd)
	);

	skd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_ready (key_ready),
		.key_char  (key_char),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.idx_req   (idx_req),
		.idx_rdata (idx_rdata),
		.key_req   (key_req),
		.key_rd    (key_rd),
		.stat      (stat)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.miss |-> stat.range_low <= stat.range_high)
		else $error("search range inverted");

	a_found_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == STS_FOUND || res_data.status == STS_INSERTED)
		|-> {1'b0, res_data.entry_id} < stat.count)
		else $error("reported id not below entry count");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.status <= STS_TOO_LONG)
		else $error("status code out of range");
endmodule
`default_nettype wire

### src/skd_index_mem.sv
`default_nettype none
module skd_index_mem (
	input  wire                        clk,
	input  skd_pkg::idx_req_t          req,
	output logic [skd_pkg::ID_W-1:0]   rdata
);
	import skd_pkg::*;

	logic [ID_W-1:0] mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rdata <= mem[req.rd_addr];
	end
endmodule
`default_nettype wire

### src/skd_key_mem.sv
`default_nettype none
module skd_key_mem (
	input  wire                clk,
	input  skd_pkg::key_req_t  req,
	output skd_pkg::key_rd_t   rd
);
	import skd_pkg::*;

	logic [CH_W-1:0]  chars [TABLE_ENTRIES * MAX_KEY_CHARS];
	logic [POS_W-1:0] lens  [TABLE_ENTRIES];

	logic [KEY_AW-1:0] wr_a;
	logic [KEY_AW-1:0] rd_a;

	assign wr_a = {req.wr_id, req.wr_pos};
	assign rd_a = {req.rd_id, req.rd_pos};

	always_ff @(posedge clk) begin
		if (req.we_char) begin
			chars[wr_a] <= req.wr_char;
		end
		rd.ch <= chars[rd_a];
	end

	always_ff @(posedge clk) begin
		if (req.we_len) begin
			lens[req.wr_id] <= req.wr_len;
		end
		rd.len <= lens[req.rd_id];
	end
endmodule
`default_nettype wire

### src/skd_ctrl.sv
`default_nettype none
module skd_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        key_valid,
	output logic                       key_ready,
	input  skd_pkg::key_beat_t         key_char,
	output logic                       res_valid,
	input  wire                        res_ready,
	output skd_pkg::result_t           res_data,
	output skd_pkg::idx_req_t          idx_req,
	input  wire [skd_pkg::ID_W-1:0]    idx_rdata,
	output skd_pkg::key_req_t          key_req,
	input  skd_pkg::key_rd_t           key_rd,
	output skd_pkg::skd_stat_t         stat
);
	import skd_pkg::*;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;

	logic signed [SL_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, j_q, j_d;
	logic [CNT_W-1:0] range_low_q, range_low_d, range_high_q, range_high_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [POS_W-1:0] ci_q, ci_d, pos_q, pos_d, k_q, k_d;
	logic miss_q, miss_d, long_q, long_d, last_q, last_d, cmd_q, cmd_d;
	logic [CH_W-1:0] c_q, c_d;
	logic [ID_W-1:0] id_q, id_d;
	result_t rslt_q, rslt_d;
	result_t out_q;
	logic out_valid_q;
	logic [CH_W-1:0] pend_q [MAX_KEY_CHARS];

	logic [CH_W-1:0] folded;
	logic [CH_W-1:0] w;
	logic accept;
	logic emit_go;
	logic signed [SL_W-1:0] rl_s;

	assign folded = (key_char.char_code >= CH_UPPER_A && key_char.char_code <= CH_UPPER_Z) ?
		key_char.char_code + CH_FOLD : key_char.char_code;
	assign w = (pos_q < key_rd.len) ? key_rd.ch : '0;
	assign accept = key_valid && key_ready;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || res_ready);
	assign rl_s = $signed({1'b0, range_low_q});

	// Next state and the search registers.
	always_comb begin
		logic do_up;
		logic do_fin;
		logic do_ins;
		state_d      = state_q;
		mode_d       = mode_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		mid_d        = mid_q;
		j_d          = j_q;
		range_low_d  = range_low_q;
		range_high_d = range_high_q;
		count_d      = count_q;
		ci_d         = ci_q;
		pos_d        = pos_q;
		k_d          = k_q;
		miss_d       = miss_q;
		long_d       = long_q;
		last_d       = last_q;
		cmd_d        = cmd_q;
		c_d          = c_q;
		id_d         = id_q;
		rslt_d       = rslt_q;
		do_up        = 1'b0;
		do_fin       = 1'b0;
		do_ins       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					last_d = key_char.last_char;
					cmd_d  = key_char.cmd;
					c_d    = folded;
					state_d = key_char.last_char ? ST_FINAL : ST_IDLE;
					if (!long_q) begin
						if (ci_q >= POS_W'(MAX_KEY_CHARS)) begin
							long_d = 1'b1;
						end else begin
							ci_d  = ci_q + 1'b1;
							pos_d = ci_q;
							if (!miss_q) begin
								lo_d    = $signed({1'b0, range_low_q});
								hi_d    = $signed({1'b0, range_high_q}) - 2'sd1;
								state_d = ST_CHK;
							end
						end
					end
				end
			end
			ST_CHK: begin
				if (lo_q <= hi_q) begin
					mid_d   = lo_q + ((hi_q - lo_q) >>> 1);
					j_d     = lo_q + ((hi_q - lo_q) >>> 1);
					mode_d  = MD_MID;
					state_d = ST_FA;
				end else begin
					range_low_d = lo_q[CNT_W-1:0];
					miss_d      = 1'b1;
					state_d     = last_q ? ST_FINAL : ST_IDLE;
				end
			end
			ST_FA: begin
				state_d = ST_FB;
			end
			ST_FB: begin
				id_d    = idx_rdata;
				state_d = ST_FC;
			end
			ST_FC: begin
				case (mode_q)
					MD_MID: begin
						if (w > c_q) begin
							hi_d    = mid_q - 2'sd1;
							state_d = ST_CHK;
						end else if (w < c_q) begin
							lo_d    = mid_q + 2'sd1;
							state_d = ST_CHK;
						end else if (mid_q - 2'sd1 >= lo_q) begin
							j_d     = mid_q - 2'sd1;
							mode_d  = MD_DOWN;
							state_d = ST_FA;
						end else begin
							lo_d  = mid_q;
							do_up = 1'b1;
						end
					end
					MD_DOWN: begin
						if (w == c_q && j_q - 2'sd1 >= lo_q) begin
							j_d     = j_q - 2'sd1;
							state_d = ST_FA;
						end else begin
							lo_d  = (w == c_q) ? j_q : j_q + 2'sd1;
							do_up = 1'b1;
						end
					end
					MD_UP: begin
						if (w == c_q && j_q + 2'sd1 <= hi_q) begin
							j_d     = j_q + 2'sd1;
							state_d = ST_FA;
						end else begin
							hi_d   = (w == c_q) ? j_q : j_q - 2'sd1;
							do_fin = 1'b1;
						end
					end
					MD_END: begin
						if (w == '0) begin
							rslt_d.status          = STS_FOUND;
							rslt_d.entry_id        = id_q;
							rslt_d.sorted_position = range_low_q[ID_W-1:0];
							state_d                = ST_EMIT;
						end else begin
							do_ins = 1'b1;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
				if (do_up) begin
					if (mid_q + 2'sd1 <= hi_q) begin
						j_d     = mid_q + 2'sd1;
						mode_d  = MD_UP;
						state_d = ST_FA;
					end else begin
						hi_d   = mid_q;
						do_fin = 1'b1;
					end
				end
				if (do_fin) begin
					range_low_d  = lo_d[CNT_W-1:0];
					range_high_d = CNT_W'(hi_d + 2'sd1);
					state_d      = last_q ? ST_FINAL : ST_IDLE;
				end
			end
			ST_FINAL: begin
				if (long_q) begin
					rslt_d.status          = STS_TOO_LONG;
					rslt_d.entry_id        = '0;
					rslt_d.sorted_position = '0;
					state_d                = ST_EMIT;
				end else if (!miss_q && range_low_q < range_high_q) begin
					pos_d   = ci_q;
					j_d     = rl_s;
					mode_d  = MD_END;
					state_d = ST_FA;
				end else begin
					do_ins = 1'b1;
				end
			end
			ST_SRD: begin
				state_d = ST_SWR;
			end
			ST_SWR: begin
				j_d     = j_q - 2'sd1;
				state_d = (j_q - 2'sd1 > rl_s) ? ST_SRD : ST_PLACE;
			end
			ST_PLACE: begin
				k_d     = '0;
				state_d = ST_KEYWR;
			end
			ST_KEYWR: begin
				k_d = k_q + 1'b1;
				if (k_q == ci_q - 1'b1) begin
					rslt_d.status   = STS_INSERTED;
					rslt_d.entry_id = count_q[ID_W-1:0];
					count_d         = count_q + 1'b1;
					state_d         = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					ci_d         = '0;
					range_low_d  = '0;
					range_high_d = count_q;
					miss_d       = 1'b0;
					long_d       = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (do_ins) begin
			rslt_d.sorted_position = range_low_q[ID_W-1:0];
			rslt_d.entry_id        = '0;
			if (cmd_q == CMD_LOOKUP) begin
				rslt_d.status = STS_MISSING;
				state_d       = ST_EMIT;
			end else if (count_q >= CNT_W'(TABLE_ENTRIES)) begin
				rslt_d.status = STS_FULL;
				state_d       = ST_EMIT;
			end else begin
				j_d     = $signed({1'b0, count_q});
				state_d = ($signed({1'b0, count_q}) > rl_s) ? ST_SRD : ST_PLACE;
			end
		end
	end

	// Memory ports and handshake.
	always_comb begin
		key_ready       = (state_q == ST_IDLE);
		idx_req.rd_addr = j_q[ID_W-1:0];
		idx_req.we      = 1'b0;
		idx_req.wr_addr = j_q[ID_W-1:0];
		idx_req.wr_data = idx_rdata;
		key_req.rd_id   = idx_rdata;
		key_req.rd_pos  = pos_q[PK_W-1:0];
		key_req.we_char = 1'b0;
		key_req.we_len  = 1'b0;
		key_req.wr_id   = count_q[ID_W-1:0];
		key_req.wr_pos  = k_q[PK_W-1:0];
		key_req.wr_char = pend_q[k_q[PK_W-1:0]];
		key_req.wr_len  = ci_q;
		case (state_q)
			ST_SRD: begin
				idx_req.rd_addr = ID_W'(j_q - 2'sd1);
			end
			ST_SWR: begin
				idx_req.we = 1'b1;
			end
			ST_PLACE: begin
				idx_req.we      = 1'b1;
				idx_req.wr_addr = range_low_q[ID_W-1:0];
				idx_req.wr_data = count_q[ID_W-1:0];
			end
			ST_KEYWR: begin
				key_req.we_char = 1'b1;
				key_req.we_len  = (k_q == ci_q - 1'b1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MD_MID;
			range_low_q  <= '0;
			range_high_q <= '0;
			count_q      <= '0;
			ci_q         <= '0;
			miss_q       <= 1'b0;
			long_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			mode_q       <= mode_d;
			range_low_q  <= range_low_d;
			range_high_q <= range_high_d;
			count_q      <= count_d;
			ci_q         <= ci_d;
			miss_q       <= miss_d;
			long_q       <= long_d;
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		mid_q  <= mid_d;
		j_q    <= j_d;
		pos_q  <= pos_d;
		k_q    <= k_d;
		last_q <= last_d;
		cmd_q  <= cmd_d;
		c_q    <= c_d;
		id_q   <= id_d;
		rslt_q <= rslt_d;
		if (emit_go) begin
			out_q <= rslt_q;
		end
		if (accept && !long_q && ci_q < POS_W'(MAX_KEY_CHARS)) begin
			pend_q[ci_q[PK_W-1:0]] <= folded;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	assign stat.count      = count_q;
	assign stat.range_low  = range_low_q;
	assign stat.range_high = range_high_q;
	assign stat.miss       = miss_q;
endmodule
`default_nettype wire

### verif/tb_sorted_key_dictionary.sv
`default_nettype none
module tb_sorted_key_dictionary;
	import skd_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int KEY_SLOTS   = 12;
	localparam int ITEM_TARGET = 950;

	logic      clk;
	logic      arst_n;
	logic      key_valid;
	logic      key_ready;
	key_beat_t key_char;
	logic      res_valid;
	logic      res_ready;
	result_t   res_data;

	sorted_key_dictionary i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_ready (key_ready),
		.key_char  (key_char),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Mirror of the dictionary contents and the search state of the current key.
	bit [CH_W-1:0] dict_chars [TABLE_ENTRIES*MAX_KEY_CHARS];
	int            dict_len   [TABLE_ENTRIES];
	int            dict_order [TABLE_ENTRIES];
	bit [CH_W-1:0] key_buf    [MAX_KEY_CHARS];
	int            dict_count;
	int            span_lo;
	int            span_hi;
	int            char_pos;
	bit            prefix_missed;
	bit            overflowed;

	key_beat_t     beat_q[$];
	result_t       lookup_q[$];
	bit [KEY_SLOTS*CH_W-1:0] seen_keys[$];
	int            seen_lens[$];
	int            beats_queued;
	int            errors;

	function automatic bit [CH_W-1:0] stored_char(int slot, int pos);
		int id;
		if (slot < 0 || slot >= TABLE_ENTRIES)
			return '0;
		id = dict_order[slot];
		if (pos < 0 || pos >= dict_len[id])
			return '0;
		return dict_chars[id*MAX_KEY_CHARS + pos];
	endfunction

	function automatic void narrow_span(bit [CH_W-1:0] c, int pos);
		int lo;
		int hi;
		int mid;
		int j;
		bit [CH_W-1:0] w;
		lo = span_lo;
		hi = span_hi - 1;
		while (lo <= hi) begin
			mid = lo + ((hi - lo) >> 1);
			w = stored_char(mid, pos);
			if (w > c) begin
				hi = mid - 1;
			end else if (w < c) begin
				lo = mid + 1;
			end else begin
				j = mid - 1;
				while (j >= lo && stored_char(j, pos) == c)
					j--;
				lo = j + 1;
				j = mid + 1;
				while (j <= hi && stored_char(j, pos) == c)
					j++;
				hi = j - 1;
				break;
			end
		end
		span_lo = lo;
		if (lo > hi)
			prefix_missed = 1'b1;
		else
			span_hi = hi + 1;
	endfunction

	function automatic void restart_key();
		char_pos      = 0;
		span_lo       = 0;
		span_hi       = dict_count;
		prefix_missed = 1'b0;
		overflowed    = 1'b0;
	endfunction

	// Advances the mirror by one beat; returns 1 when the beat closes a key.
	function automatic bit dict_step(key_beat_t b, output result_t r);
		bit [CH_W-1:0] c;
		int n;
		int p;
		int j;
		c = b.char_code;
		r = '0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
			c = c + CH_FOLD;
		if (!overflowed) begin
			if (char_pos >= MAX_KEY_CHARS) begin
				overflowed = 1'b1;
			end else begin
				key_buf[char_pos] = c;
				if (!prefix_missed)
					narrow_span(c, char_pos);
				char_pos++;
			end
		end
		if (!b.last_char)
			return 1'b0;
		n = char_pos;
		if (overflowed) begin
			r.status = STS_TOO_LONG;
		end else if (!prefix_missed && span_lo < span_hi && stored_char(span_lo, n) == '0) begin
			r.status          = STS_FOUND;
			r.entry_id        = ID_W'(dict_order[span_lo]);
			r.sorted_position = ID_W'(span_lo);
		end else begin
			p = span_lo;
			r.sorted_position = ID_W'(p);
			if (b.cmd == CMD_LOOKUP) begin
				r.status = STS_MISSING;
			end else if (dict_count >= TABLE_ENTRIES || p < 0 || p > dict_count) begin
				r.status = STS_FULL;
			end else begin
				for (j = dict_count; j > p; j--)
					dict_order[j] = dict_order[j-1];
				dict_order[p] = dict_count;
				for (j = 0; j < n; j++)
					dict_chars[dict_count*MAX_KEY_CHARS + j] = key_buf[j];
				dict_len[dict_count] = n;
				r.status   = STS_INSERTED;
				r.entry_id = ID_W'(dict_count);
				dict_count++;
			end
		end
		restart_key();
		return 1'b1;
	endfunction

	function automatic bit [CH_W-1:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return CH_W'(16'h0061 + $urandom_range(0, 3));
			5, 6:          return CH_W'(CH_UPPER_A + $urandom_range(0, 3));
			7:             return '0;
			8:             return CH_W'($urandom_range(0, 65535));
			default:       return CH_W'(16'h0061 + $urandom_range(0, 25));
		endcase
	endfunction

	// Queues one key, its beats and the result it should produce.
	task automatic queue_key(bit [KEY_SLOTS*CH_W-1:0] chars, int len, logic cmd);
		key_beat_t b;
		result_t   r;
		for (int i = 0; i < len; i++) begin
			b.char_code = chars[i*CH_W +: CH_W];
			b.last_char = (i == len - 1);
			b.cmd       = b.last_char ? cmd : 1'($urandom_range(0, 1));
			beat_q.push_back(b);
			beats_queued++;
			if (dict_step(b, r))
				lookup_q.push_back(r);
		end
		if (len <= MAX_KEY_CHARS) begin
			seen_keys.push_back(chars);
			seen_lens.push_back(len);
		end
	endtask

	task automatic queue_text(string s, logic cmd);
		bit [KEY_SLOTS*CH_W-1:0] k;
		k = '0;
		for (int i = 0; i < s.len(); i++)
			k[i*CH_W +: CH_W] = CH_W'(s[i]);
		queue_key(k, s.len(), cmd);
	endtask

	initial begin
		bit [KEY_SLOTS*CH_W-1:0] k;
		int len;
		int idx;
		int sel;
		int fill;
		errors       = 0;
		beats_queued = 0;
		dict_count   = 0;
		restart_key();

		// Directed keys: folding edges, prefixes, end-of-key zero, overlength.
		queue_text("a", CMD_INSERT);
		queue_text("abc", CMD_INSERT);
		queue_text("AB", CMD_INSERT);
		queue_text("ab", CMD_LOOKUP);
		queue_text("abd", CMD_LOOKUP);
		k = '0;
		k[0 +: CH_W]    = 16'h0061;
		queue_key(k, 2, CMD_LOOKUP);
		k = '0;
		k[5*CH_W-1:0] = {16'h005B, 16'h0040, 16'h005A, 16'h0041, 16'hFFFF};
		queue_key(k, 5, CMD_INSERT);
		queue_text("abcdefgh", CMD_INSERT);
		queue_text("ABCDEFGHI", CMD_INSERT);

		// Leave room for the fill phase so the whole run stays near the target.
		while (beats_queued + (TABLE_ENTRIES - dict_count) < ITEM_TARGET - 10) begin
			sel = $urandom_range(0, 99);
			if (sel < 50 || seen_keys.size() == 0) begin
				case ($urandom_range(0, 9))
					0:       len = 8;
					1:       len = $urandom_range(9, KEY_SLOTS);
					default: len = $urandom_range(1, 4);
				endcase
				for (int i = 0; i < KEY_SLOTS; i++)
					k[i*CH_W +: CH_W] = pick_char();
				queue_key(k, len, (sel < 40) ? CMD_INSERT : CMD_LOOKUP);
			end else begin
				idx = $urandom_range(0, seen_keys.size() - 1);
				k   = seen_keys[idx];
				len = seen_lens[idx];
				// Sometimes trim or extend a known key to probe neighbors.
				if (sel >= 90) begin
					if ($urandom_range(0, 1) && len > 1) begin
						len--;
					end else begin
						k[len*CH_W +: CH_W] = pick_char();
						len++;
					end
				end
				queue_key(k, len, (sel < 75) ? CMD_LOOKUP : CMD_INSERT);
			end
		end

		// Fill the table with ascending one-character keys, then overflow it.
		fill = 0;
		while (dict_count < TABLE_ENTRIES) begin
			k = '0;
			k[0 +: CH_W] = CH_W'(16'h8000 + fill);
			queue_key(k, 1, CMD_INSERT);
			fill++;
		end
		queue_text("zz", CMD_INSERT);
		k = '0;
		k[0 +: CH_W] = 16'h0010;
		queue_key(k, 1, CMD_INSERT);
		queue_text("a", CMD_LOOKUP);
		queue_text("zz", CMD_LOOKUP);

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (beat_q.size() == 0 && !key_valid && lookup_q.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Key channel driver; a burst phase sends without gaps.
	int  send_gap;
	int  send_count;
	bit  send_burst;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid  <= 1'b0;
			key_char   <= '0;
			send_gap   <= 0;
			send_count <= 0;
			send_burst <= 1'b0;
		end else if (!key_valid || key_ready) begin
			if (send_gap > 0) begin
				key_valid <= 1'b0;
				send_gap  <= send_gap - 1;
			end else if (beat_q.size() > 0) begin
				key_char   <= beat_q.pop_front();
				key_valid  <= 1'b1;
				send_count <= send_count + 1;
				if (send_count % 60 == 0)
					send_burst <= $urandom_range(0, 3) == 0;
				send_gap   <= send_burst ? 0 : $urandom_range(0, 14);
			end else begin
				key_valid <= 1'b0;
			end
		end
	end

	// Result channel monitor with random back-pressure.
	int      hold;
	int      res_count;
	result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			hold      <= 0;
			res_count <= 0;
		end else if (res_valid && res_ready) begin
			res_count <= res_count + 1;
			if (lookup_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: status %0d id %0d pos %0d",
						res_data.status, res_data.entry_id, res_data.sorted_position);
			end else begin
				want = lookup_q.pop_front();
				if (res_data.status !== want.status || res_data.entry_id !== want.entry_id
						|| res_data.sorted_position !== want.sorted_position) begin
					errors++;
					if (errors <= 10)
						$display("result %0d: expected status %0d id %0d pos %0d, got %0d %0d %0d",
							res_count, want.status, want.entry_id, want.sorted_position,
							res_data.status, res_data.entry_id, res_data.sorted_position);
				end
			end
			hold      <= (res_count % 80 < 20) ? 0 : $urandom_range(0, 14);
			res_ready <= 1'b0;
		end else if (hold > 0) begin
			hold      <= hold - 1;
			res_ready <= (hold == 1);
		end else begin
			res_ready <= 1'b1;
		end
	end

	int idle_cycles;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((key_valid && key_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
`default_nettype wire

### sorted_key_dictionary.f
src/skd_pkg.sv
src/skd_index_mem.sv
src/skd_key_mem.sv
src/skd_ctrl.sv
src/sorted_key_dictionary.sv
verif/tb_sorted_key_dictionary.sv
